FILE: rtl/uamrw_pkg.sv
package uamrw_pkg;

    localparam int ADDR_W     = 64;
    localparam int UNIT_W     = 33;
    localparam int BBYTES_W   = 5;
    localparam int BYTE_BITS  = 8;
    localparam int WORD_W     = 64;
    localparam int WORDS      = 2;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_PRESENT = 3'd0,
        REG_BASE_ADDRESS  = 3'd1,
        REG_UNIT_BYTES    = 3'd2,
        REG_BITMAP_BYTES  = 3'd3
    } t_reg_idx;

    typedef enum logic {
        REQ_ACCEPT = 1'b0,
        REQ_LOAD   = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_RD,
        S_LD,
        S_WALK,
        S_WB,
        S_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/unaccepted_memory_run_walker_core.sv
// Unaccepted memory run walker. A load request writes one 64-bit bitmap word, and loads
// can follow each other every cycle while no accept is in progress. An accept request
// clips the byte range and converts it to unit indices with a 64-step bit-serial divider,
// then walks the bitmap out of a two-word RAM, one unit per cycle while the output is not
// stalled, clearing set bits and writing each word back: each bitmap word visited is read,
// loaded, walked unit by unit and written back, and a final step closes the request.
// Runs come out on the result channel in address order, the last one flagged; the walk
// pauses while a finished run cannot be handed to the output register.
module unaccepted_memory_run_walker_core #(
    parameter int BITMAP_BITS = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic [uamrw_pkg::ADDR_W-1:0]          i_start_addr,
    input  logic [uamrw_pkg::ADDR_W-1:0]          i_length,
    input  logic                                  i_word_index,
    input  logic [uamrw_pkg::WORD_W-1:0]          i_word_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [uamrw_pkg::ADDR_W-1:0]          o_run_start_addr,
    output logic [uamrw_pkg::ADDR_W-1:0]          o_run_end_addr,
    output logic                                  o_last_run,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [uamrw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [uamrw_pkg::ADDR_W-1:0]          i_cfg_data
);
    import uamrw_pkg::*;

    localparam int        IDX_W = 8;
    localparam logic [IDX_W-1:0] STOP_MAX = IDX_W'(BITMAP_BITS);
    localparam int        LIM_W = BBYTES_W + UNIT_W + $clog2(BYTE_BITS);

    t_state r_state, n_state;

    logic                 r_present;
    logic [ADDR_W-1:0]    r_base;
    logic [UNIT_W-1:0]    r_unit;
    logic [BBYTES_W-1:0]  r_bbytes;
    logic [LIM_W-1:0]     r_limit;
    logic [BBYTES_W+UNIT_W-1:0] lim_prod;

    logic [ADDR_W-1:0]    r_sa, r_len;
    logic [IDX_W-1:0]     r_i, r_stop, r_rb, r_pb, r_pe;
    logic                 r_in_run, r_pv, r_w;
    logic [WORD_W-1:0]    r_word;
    logic [WORDS-1:0]     r_wvld;
    logic                 r_ov, r_olast;
    logic [ADDR_W-1:0]    r_os, r_oe;
    logic [IDX_W+UNIT_W-1:0] s_prod, e_prod;

    // prep datapath
    logic [ADDR_W-1:0]    end_abs, st_rel, end_rel, end_clip;
    logic                 prep_none;
    // divider
    logic                 div_load;
    t_div_stat            div_stat;
    logic [ADDR_W-1:0]    q_a, q_b;
    logic                 rb_nz;
    logic [IDX_W-1:0]     first_idx, stop_idx;
    // walk
    logic                 cur_bit, at_end, fin_run, out_free, stall, push_mid, push_fin;
    logic                 ram_we, ram_waddr, ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;
    logic                 in_acc, cfg_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_base    <= '0;
            r_unit    <= UNIT_W'(2097152);
            r_bbytes  <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                REG_TABLE_PRESENT: r_present <= i_cfg_data[0];
                REG_BASE_ADDRESS:  r_base    <= i_cfg_data;
                REG_UNIT_BYTES:    r_unit    <= i_cfg_data[UNIT_W-1:0];
                REG_BITMAP_BYTES:  r_bbytes  <= i_cfg_data[BBYTES_W-1:0];
                default: ;
            endcase
        end
    end

    assign lim_prod = r_bbytes * r_unit;

    always_ff @(posedge i_clk) begin
        r_limit <= {lim_prod, 3'b000};
    end

    always_comb begin
        end_abs   = r_sa + r_len;
        prep_none = (end_abs < r_base);
        st_rel    = ((r_sa < r_base) ? r_base : r_sa) - r_base;
        end_rel   = end_abs - r_base;
        end_clip  = (end_rel > ADDR_W'(r_limit)) ? ADDR_W'(r_limit) : end_rel;
    end

    assign div_load = (r_state == S_PREP) && !prep_none;

    uamrw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_num_a    (st_rel),
        .i_num_b    (end_clip),
        .i_den      (r_unit),
        .o_stat     (div_stat),
        .o_quo_a    (q_a),
        .o_quo_b    (q_b),
        .o_rem_b_nz (rb_nz)
    );

    always_comb begin
        first_idx = (q_a > ADDR_W'(128)) ? IDX_W'(128) : IDX_W'(q_a);
        if (q_b >= ADDR_W'(STOP_MAX)) begin
            stop_idx = STOP_MAX;
        end else begin
            stop_idx = IDX_W'(q_b) + IDX_W'(rb_nz);
            if (stop_idx > STOP_MAX) begin
                stop_idx = STOP_MAX;
            end
        end
    end

    always_comb begin
        cur_bit  = r_word[r_i[5:0]];
        at_end   = (r_i == r_stop);
        fin_run  = r_in_run && (at_end || !cur_bit);
        out_free = !r_ov || i_out_ready;
        stall    = fin_run && r_pv && !out_free;
        push_mid = (r_state == S_WALK) && fin_run && r_pv && out_free;
        push_fin = (r_state == S_FIN) && r_pv && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_req_type == REQ_ACCEPT && r_present && r_unit != '0) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = prep_none ? S_IDLE : S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = (first_idx >= stop_idx) ? S_IDLE : S_RD;
                end
            end
            S_RD:   n_state = S_LD;
            S_LD:   n_state = S_WALK;
            S_WALK: begin
                if (!stall && (at_end || r_i[5:0] == 6'h3f)) begin
                    n_state = S_WB;
                end
            end
            // a run still open at a word boundary is closed by one more visit
            S_WB:   n_state = (r_i < r_stop || r_in_run) ? S_RD : S_FIN;
            S_FIN: begin
                if (!r_pv || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs to RAM and handshake
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        ram_we     = 1'b0;
        ram_waddr  = r_w;
        ram_wdata  = r_word;
        ram_raddr  = r_i[6];
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_req_type == REQ_LOAD) begin
                    ram_we    = 1'b1;
                    ram_waddr = i_word_index;
                    ram_wdata = i_word_value;
                end
            end
            S_WB:   ram_we = 1'b1;
            default: ;
        endcase
    end

    uamrw_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_in_run <= 1'b0;
            r_ov     <= 1'b0;
            r_wvld   <= '0;
        end else begin
            r_state <= n_state;
            // words never written since reset read as zero
            if (ram_we) begin
                r_wvld[ram_waddr] <= 1'b1;
            end
            if (push_mid || push_fin) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_DIV) begin
                r_in_run <= 1'b0;
                r_pv     <= 1'b0;
            end
            if (r_state == S_WALK && !stall) begin
                if (fin_run) begin
                    r_pv     <= 1'b1;
                    r_in_run <= 1'b0;
                end
                if (!at_end && cur_bit && !r_in_run) begin
                    r_in_run <= 1'b1;
                end
            end
            if (push_fin) begin
                r_pv <= 1'b0;
            end
        end
    end

    assign s_prod = r_pb * r_unit;
    assign e_prod = r_pe * r_unit;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sa  <= i_start_addr;
            r_len <= i_length;
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_i    <= first_idx;
            r_stop <= stop_idx;
        end
        if (r_state == S_RD) begin
            r_w <= r_i[6];
        end
        if (r_state == S_LD) begin
            r_word <= r_wvld[r_w] ? ram_rdata : '0;
        end
        if (r_state == S_WALK && !stall) begin
            if (fin_run) begin
                r_pb <= r_rb;
                r_pe <= r_i;
            end
            if (!at_end) begin
                if (cur_bit) begin
                    r_word[r_i[5:0]] <= 1'b0;
                    if (!r_in_run) begin
                        r_rb <= r_i;
                    end
                end
                r_i <= r_i + 1'b1;
            end
        end
        if (push_mid || push_fin) begin
            r_os    <= ADDR_W'(s_prod) + r_base;
            r_oe    <= ADDR_W'(e_prod) + r_base;
            r_olast <= push_fin;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_run_start_addr = r_os;
    assign o_run_end_addr   = r_oe;
    assign o_last_run       = r_olast;
endmodule

FILE: rtl/uamrw_ram.sv
module uamrw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/uamrw_div.sv
// Two restoring dividers sharing one divisor and one step counter, one quotient bit a cycle.
module uamrw_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [uamrw_pkg::ADDR_W-1:0]  i_num_a,
    input  logic [uamrw_pkg::ADDR_W-1:0]  i_num_b,
    input  logic [uamrw_pkg::UNIT_W-1:0]  i_den,
    output uamrw_pkg::t_div_stat          o_stat,
    output logic [uamrw_pkg::ADDR_W-1:0]  o_quo_a,
    output logic [uamrw_pkg::ADDR_W-1:0]  o_quo_b,
    output logic                          o_rem_b_nz
);
    import uamrw_pkg::*;

    logic [ADDR_W-1:0]          r_qa, r_qb, n_qa, n_qb;
    logic [UNIT_W-1:0]          r_ra, r_rb, n_ra, n_rb;
    logic [$clog2(ADDR_W)-1:0]  r_cnt;
    logic                       r_busy, r_done;
    logic [UNIT_W:0]            sh_a, sh_b;

    always_comb begin
        sh_a = {r_ra, r_qa[ADDR_W-1]};
        sh_b = {r_rb, r_qb[ADDR_W-1]};
        n_qa = {r_qa[ADDR_W-2:0], 1'b0};
        n_qb = {r_qb[ADDR_W-2:0], 1'b0};
        n_ra = sh_a[UNIT_W-1:0];
        n_rb = sh_b[UNIT_W-1:0];
        if (sh_a >= {1'b0, i_den}) begin
            n_ra  = UNIT_W'(sh_a - {1'b0, i_den});
            n_qa[0] = 1'b1;
        end
        if (sh_b >= {1'b0, i_den}) begin
            n_rb  = UNIT_W'(sh_b - {1'b0, i_den});
            n_qb[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_qa <= i_num_a;
            r_qb <= i_num_b;
            r_ra <= '0;
            r_rb <= '0;
        end else if (r_busy) begin
            r_qa <= n_qa;
            r_qb <= n_qb;
            r_ra <= n_ra;
            r_rb <= n_rb;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo_a     = r_qa;
    assign o_quo_b     = r_qb;
    assign o_rem_b_nz  = (r_rb != '0);
endmodule

FILE: rtl/uamrw_checker.sv
module uamrw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_req_type,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_run_start_addr,
    input logic [63:0] o_run_end_addr
);
    import uamrw_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_run_start_addr)
            && $stable(o_run_end_addr))
        else $error("result changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_req_type == REQ_LOAD |=> !$rose(o_out_valid))
        else $error("load produced a result");

    // an accept needs the clip and divide steps before any run can come out
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_req_type == REQ_ACCEPT |=> !$rose(o_out_valid))
        else $error("accept produced a result too early");
endmodule

bind unaccepted_memory_run_walker_core uamrw_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_req_type       (i_req_type),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_run_start_addr (o_run_start_addr),
    .o_run_end_addr   (o_run_end_addr)
);
